[sv/assert_macros.svh]
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// Check that an expression never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");

`endif

[sv/stwalk_pkg.sv]
package stwalk_pkg;

   localparam int MAX_DIMS     = 4;
   localparam int DIM_BITS     = 12;
   localparam int OFFSET_BITS  = 24;
   localparam int NUM_TENSORS  = 3;
   localparam int PACK_BITS    = MAX_DIMS * DIM_BITS;
   localparam int ACT_BITS     = 3;
   localparam int CSR_IDX_BITS = 3;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_ACTIVE_DIMS = 3'd0,
      CSR_DIM_SIZES   = 3'd1,
      CSR_STRIDES_A   = 3'd2,
      CSR_STRIDES_B   = 3'd3,
      CSR_STRIDES_C   = 3'd4
   } csr_idx_type;

   typedef enum logic {
      ACT_START   = 1'b0,
      ACT_ADVANCE = 1'b1
   } action_type;

   typedef logic [NUM_TENSORS-1:0][OFFSET_BITS-1:0] offs_type;
   typedef logic [NUM_TENSORS-1:0][DIM_BITS-1:0]    strd_type;

   typedef struct packed {
      logic                   action;
      logic [OFFSET_BITS-1:0] base_a;
      logic [OFFSET_BITS-1:0] base_b;
      logic [OFFSET_BITS-1:0] base_c;
   } req_type;

   typedef struct packed {
      logic [OFFSET_BITS-1:0] offset_a_out;
      logic [OFFSET_BITS-1:0] offset_b_out;
      logic [OFFSET_BITS-1:0] offset_c_out;
      logic [PACK_BITS-1:0]   index_out;
      logic                   wrapped;
   } rsp_type;

   typedef struct packed {
      logic start;
      logic active;
      logic carry_in;
   } cell_ctl_type;

   typedef struct packed {
      logic                carry_out;
      logic [DIM_BITS-1:0] idx_next;
   } cell_stat_type;

endpackage

[sv/stwalk_cell.sv]
module stwalk_cell
   import stwalk_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic [DIM_BITS-1:0] size,
   input  strd_type      stride,
   input  cell_ctl_type  ctl,
   input  offs_type      acc_in,
   output offs_type      acc_out,
   output cell_stat_type stat
);

   logic [DIM_BITS-1:0]   idx_ff;
   logic [DIM_BITS-1:0]   idx_in;
   offs_type              rewind_ff;
   offs_type              rewind_in;
   logic [DIM_BITS-1:0]   size_eff;
   logic [DIM_BITS-1:0]   last;
   logic                  bump_ok;
   logic [NUM_TENSORS-1:0][2*DIM_BITS-1:0] prod;

   assign size_eff = (size == '0) ? DIM_BITS'(1) : size;
   assign last     = size_eff - DIM_BITS'(1);
   assign bump_ok  = ((DIM_BITS+1)'(idx_ff) + (DIM_BITS+1)'(1)) < (DIM_BITS+1)'(size_eff);

   always_comb begin
      for (int t = 0; t < NUM_TENSORS; t++) begin
         prod[t]      = (2*DIM_BITS)'(stride[t]) * (2*DIM_BITS)'(last);
         rewind_in[t] = OFFSET_BITS'(prod[t]);
      end
   end

   always_comb begin
      idx_in         = idx_ff;
      acc_out        = acc_in;
      stat.carry_out = 1'b0;
      if (ctl.start) begin
         idx_in = '0;
      end else if (ctl.active && ctl.carry_in) begin
         if (bump_ok) begin
            idx_in = idx_ff + DIM_BITS'(1);
            for (int t = 0; t < NUM_TENSORS; t++) begin
               acc_out[t] = acc_in[t] + OFFSET_BITS'(stride[t]);
            end
         end else begin
            idx_in = '0;
            for (int t = 0; t < NUM_TENSORS; t++) begin
               acc_out[t] = acc_in[t] - rewind_ff[t];
            end
            stat.carry_out = 1'b1;
         end
      end
      stat.idx_next = idx_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      rewind_ff <= rewind_in;
   end

endmodule

[sv/strided_tensor_address_walker_core.sv]
// Odometer address walker for up to three strided tensors (A, B, result C).
// Request channel (req_valid, req_stall, req_data): a start request loads the
// three base offsets and clears every index; an advance request steps the
// innermost active dimension and carries outward through the dimension cells.
// Response channel (rsp_valid, rsp_stall, rsp_data): one response per request
// with the offsets and packed indices after the step, plus a wrapped flag.
// Each response is registered and shows in the cycle after its request is
// taken; one request per cycle is taken while req_stall is low. While the
// response register is full and rsp_stall is high, req_stall is raised and
// the response holds. Registers are written through csr_we, csr_index and
// csr_wdata while the walker is idle, a rule for the user that the block
// does not enforce. The cycle after a write the request channel is stalled
// while each cell refreshes its rewind amount. Reset clears the registers,
// the indices and the offsets; no response is pending after reset.
`include "assert_macros.svh"

module strided_tensor_address_walker_core
   import stwalk_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  req_type                 req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output rsp_type                 rsp_data,
   input  logic                    csr_we,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [PACK_BITS-1:0]    csr_wdata
);

   logic [ACT_BITS-1:0]                  active_dims_ff;
   logic [PACK_BITS-1:0]                 dim_sizes_ff;
   logic [NUM_TENSORS-1:0][PACK_BITS-1:0] strides_ff;
   logic                                 cfg_pend_ff;
   offs_type                             offs_ff;
   offs_type                             offs_in;
   logic                                 rsp_valid_ff;
   rsp_type                              rsp_data_ff;
   rsp_type                              rsp_data_in;

   logic                 accept;
   logic                 advance;
   logic                 start;
   logic [ACT_BITS-1:0]  n_act;
   logic [PACK_BITS-1:0] idx_pack;
   offs_type             acc [MAX_DIMS+1];
   cell_ctl_type         ctl [MAX_DIMS];
   cell_stat_type        stat [MAX_DIMS];
   strd_type             cell_stride [MAX_DIMS];

   assign req_stall = cfg_pend_ff | (rsp_valid_ff & rsp_stall);
   assign accept    = req_valid & ~req_stall;
   assign advance   = accept & (req_data.action == ACT_ADVANCE);
   assign start     = accept & (req_data.action == ACT_START);
   assign n_act     = (active_dims_ff > ACT_BITS'(MAX_DIMS)) ? ACT_BITS'(MAX_DIMS)
                                                            : active_dims_ff;
   assign acc[MAX_DIMS] = offs_ff;

   for (genvar d = 0; d < MAX_DIMS; d++) begin : g_cell
      for (genvar t = 0; t < NUM_TENSORS; t++) begin : g_lane
         assign cell_stride[d][t] = strides_ff[t][d*DIM_BITS +: DIM_BITS];
      end

      assign ctl[d].start  = start;
      assign ctl[d].active = ACT_BITS'(d) < n_act;
      if (d == MAX_DIMS - 1) begin : g_inner
         assign ctl[d].carry_in = advance & (ACT_BITS'(d + 1) == n_act);
      end else begin : g_outer
         assign ctl[d].carry_in = advance &
                                  ((ACT_BITS'(d + 1) == n_act) | stat[d+1].carry_out);
      end

      stwalk_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .size    (dim_sizes_ff[d*DIM_BITS +: DIM_BITS]),
         .stride  (cell_stride[d]),
         .ctl     (ctl[d]),
         .acc_in  (acc[d+1]),
         .acc_out (acc[d]),
         .stat    (stat[d])
      );

      assign idx_pack[d*DIM_BITS +: DIM_BITS] = stat[d].idx_next;
   end

   always_comb begin
      if (start) begin
         offs_in[0] = req_data.base_a;
         offs_in[1] = req_data.base_b;
         offs_in[2] = req_data.base_c;
      end else begin
         offs_in = acc[0];
      end
      rsp_data_in.offset_a_out = offs_in[0];
      rsp_data_in.offset_b_out = offs_in[1];
      rsp_data_in.offset_c_out = offs_in[2];
      rsp_data_in.index_out    = idx_pack;
      rsp_data_in.wrapped      = advance & ((n_act == '0) | stat[0].carry_out);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_dims_ff <= '0;
         dim_sizes_ff   <= '0;
         strides_ff     <= '0;
         cfg_pend_ff    <= 1'b0;
      end else begin
         cfg_pend_ff <= csr_we;
         if (csr_we) begin
            unique case (csr_idx_type'(csr_index))
               CSR_ACTIVE_DIMS: active_dims_ff <= csr_wdata[ACT_BITS-1:0];
               CSR_DIM_SIZES:   dim_sizes_ff   <= csr_wdata;
               CSR_STRIDES_A:   strides_ff[0]  <= csr_wdata;
               CSR_STRIDES_B:   strides_ff[1]  <= csr_wdata;
               CSR_STRIDES_C:   strides_ff[2]  <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offs_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            offs_ff      <= offs_in;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `ASSERT_CLK(a_cfg_write_blocks_req, clock, reset, csr_we |=> req_stall)
   `ASSERT_CLK(a_start_clears_index, clock, reset,
      start |=> (rsp_valid && rsp_data.index_out == '0 && !rsp_data.wrapped))
   `ASSERT_NEVER(a_wrap_without_advance, clock, reset, rsp_data_in.wrapped && !advance)

endmodule

[test/tb_strided_tensor_address_walker_core.sv]
`timescale 1ns / 100ps

module tb_strided_tensor_address_walker_core;
   import stwalk_pkg::*;

   logic                    clock;
   logic                    reset     = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   req_type                 req_data  = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   rsp_type                 rsp_data;
   logic                    csr_we    = 1'b0;
   logic [CSR_IDX_BITS-1:0] csr_index = CSR_ACTIVE_DIMS;
   logic [PACK_BITS-1:0]    csr_wdata = '0;

   strided_tensor_address_walker_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // walker copy: registers and running state
   logic [ACT_BITS-1:0]    mdl_active  = '0;
   logic [PACK_BITS-1:0]   mdl_sizes   = '0;
   logic [PACK_BITS-1:0]   mdl_strides [NUM_TENSORS] = '{default: '0};
   logic [DIM_BITS-1:0]    mdl_idx     [MAX_DIMS]    = '{default: '0};
   logic [OFFSET_BITS-1:0] mdl_off     [NUM_TENSORS] = '{default: '0};

   req_type walk_cmd_q [$];
   rsp_type due_addr_q [$];

   int  cmds_made       = 0;
   int  reqs_sent       = 0;
   int  starts_sent     = 0;
   int  rsps_checked    = 0;
   int  settings_loaded = 0;
   int  fail_count      = 0;
   int  req_wait        = 0;
   int  rsp_wait        = 0;
   bit  req_calm        = 1'b0;
   bit  rsp_calm        = 1'b0;

   function automatic int draw_wait(bit calm);
      return calm ? 0 : $urandom_range(0, 8);
   endfunction

   function automatic logic [OFFSET_BITS-1:0] rand_off();
      return OFFSET_BITS'($urandom);
   endfunction

   function automatic logic [PACK_BITS-1:0] rand_strides();
      logic [PACK_BITS-1:0] s;
      int d;
      s = '0;
      for (d = 0; d < MAX_DIMS; d++) begin
         case ($urandom_range(0, 5))
            0: s[DIM_BITS*d +: DIM_BITS] = '0;
            1: s[DIM_BITS*d +: DIM_BITS] = '1;
            2, 3: s[DIM_BITS*d +: DIM_BITS] = DIM_BITS'($urandom_range(0, 4095));
            default: s[DIM_BITS*d +: DIM_BITS] = DIM_BITS'($urandom_range(1, 8));
         endcase
      end
      return s;
   endfunction

   // step the walker copy by one request and return the address set it yields
   function automatic rsp_type advance_walk(req_type cmd);
      rsp_type     res;
      int unsigned lim, size, last, stride;
      int          d, t;
      bit          carry;
      res = '0;
      if (cmd.action == ACT_START) begin
         mdl_off[0] = cmd.base_a;
         mdl_off[1] = cmd.base_b;
         mdl_off[2] = cmd.base_c;
         for (d = 0; d < MAX_DIMS; d++) mdl_idx[d] = '0;
         carry = 1'b0;
      end else begin
         lim   = (int'(mdl_active) > MAX_DIMS) ? MAX_DIMS : int'(mdl_active);
         carry = 1'b1;
         for (d = int'(lim) - 1; d >= 0 && carry; d--) begin
            size = 32'(mdl_sizes[DIM_BITS*d +: DIM_BITS]);
            if (size == 0) size = 1;
            if (32'(mdl_idx[d]) + 1 < size) begin
               mdl_idx[d] = mdl_idx[d] + 1'b1;
               for (t = 0; t < NUM_TENSORS; t++)
                  mdl_off[t] = mdl_off[t] +
                               OFFSET_BITS'(mdl_strides[t][DIM_BITS*d +: DIM_BITS]);
               carry = 1'b0;
            end else begin
               last = size - 1;
               for (t = 0; t < NUM_TENSORS; t++) begin
                  stride     = 32'(mdl_strides[t][DIM_BITS*d +: DIM_BITS]);
                  mdl_off[t] = mdl_off[t] - OFFSET_BITS'(stride * last);
               end
               mdl_idx[d] = '0;
            end
         end
      end
      res.offset_a_out = mdl_off[0];
      res.offset_b_out = mdl_off[1];
      res.offset_c_out = mdl_off[2];
      for (d = 0; d < MAX_DIMS; d++) res.index_out[DIM_BITS*d +: DIM_BITS] = mdl_idx[d];
      res.wrapped = carry;
      return res;
   endfunction

   always @(posedge clock) begin
      if (!reset && csr_we) begin
         case (csr_index)
            CSR_ACTIVE_DIMS: mdl_active     = csr_wdata[ACT_BITS-1:0];
            CSR_DIM_SIZES:   mdl_sizes      = csr_wdata;
            CSR_STRIDES_A:   mdl_strides[0] = csr_wdata;
            CSR_STRIDES_B:   mdl_strides[1] = csr_wdata;
            CSR_STRIDES_C:   mdl_strides[2] = csr_wdata;
            default: ;
         endcase
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            due_addr_q.push_back(advance_walk(req_data));
            if (req_data.action == ACT_START) starts_sent++;
            reqs_sent++;
         end
         // hold a stalled request as it is
         if (!req_valid || !req_stall) begin
            if (req_wait > 0) begin
               req_wait--;
               req_valid <= 1'b0;
            end else if (walk_cmd_q.size() > 0) begin
               req_data  <= walk_cmd_q.pop_front();
               req_valid <= 1'b1;
               if ($urandom_range(0, 39) == 0) req_calm = ~req_calm;
               req_wait = draw_wait(req_calm);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (due_addr_q.size() == 0) begin
               $error("response with no request outstanding");
               fail_count++;
            end else begin
               want = due_addr_q.pop_front();
               rsps_checked++;
               if (rsp_data.offset_a_out !== want.offset_a_out) begin
                  $error("offset_a_out: expected %h, got %h",
                         want.offset_a_out, rsp_data.offset_a_out);
                  fail_count++;
               end
               if (rsp_data.offset_b_out !== want.offset_b_out) begin
                  $error("offset_b_out: expected %h, got %h",
                         want.offset_b_out, rsp_data.offset_b_out);
                  fail_count++;
               end
               if (rsp_data.offset_c_out !== want.offset_c_out) begin
                  $error("offset_c_out: expected %h, got %h",
                         want.offset_c_out, rsp_data.offset_c_out);
                  fail_count++;
               end
               if (rsp_data.index_out !== want.index_out) begin
                  $error("index_out: expected %h, got %h",
                         want.index_out, rsp_data.index_out);
                  fail_count++;
               end
               if (rsp_data.wrapped !== want.wrapped) begin
                  $error("wrapped: expected %b, got %b", want.wrapped, rsp_data.wrapped);
                  fail_count++;
               end
            end
            if ($urandom_range(0, 39) == 0) rsp_calm = ~rsp_calm;
            rsp_wait = draw_wait(rsp_calm);
         end
         if (rsp_wait > 0) begin
            rsp_wait--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic put_reg(csr_idx_type idx, logic [PACK_BITS-1:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
   endtask

   task automatic set_walk(logic [ACT_BITS-1:0] act, logic [PACK_BITS-1:0] sizes,
                           logic [PACK_BITS-1:0] sa, logic [PACK_BITS-1:0] sb,
                           logic [PACK_BITS-1:0] sc);
      put_reg(CSR_ACTIVE_DIMS, PACK_BITS'(act));
      put_reg(CSR_DIM_SIZES, sizes);
      put_reg(CSR_STRIDES_A, sa);
      put_reg(CSR_STRIDES_B, sb);
      put_reg(CSR_STRIDES_C, sc);
      @(posedge clock);
      csr_we <= 1'b0;
      settings_loaded++;
      @(negedge clock);
   endtask

   task automatic push_cmd(action_type a, logic [OFFSET_BITS-1:0] ba,
                           logic [OFFSET_BITS-1:0] bb, logic [OFFSET_BITS-1:0] bc);
      req_type cmd;
      cmd.action = a;
      cmd.base_a = ba;
      cmd.base_b = bb;
      cmd.base_c = bc;
      walk_cmd_q.push_back(cmd);
      cmds_made++;
   endtask

   task automatic drain();
      do @(negedge clock);
      while (walk_cmd_q.size() != 0 || req_valid || due_addr_q.size() != 0);
   endtask

   initial begin
      logic [ACT_BITS-1:0]  act;
      logic [PACK_BITS-1:0] sizes, sa, sb, sc;
      int span, steps, lim, mark, sz, d, directed;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // full walk with a zero-size dimension, wrap-around bases and max strides on A
      set_walk(3'd4, {12'd2, 12'd3, 12'd0, 12'd2}, '1,
               {12'd1, 12'd16, 12'd256, 12'h800}, '0);
      push_cmd(ACT_START, 24'hFFFFFF, 24'h000000, 24'h800000);
      repeat (13) push_cmd(ACT_ADVANCE, rand_off(), rand_off(), rand_off());
      drain();

      // shrink sizes mid-walk, active count past the dimension count
      set_walk(3'd7, {12'd1, 12'd2, 12'd0, 12'd2}, rand_strides(), rand_strides(),
               rand_strides());
      repeat (3) push_cmd(ACT_ADVANCE, rand_off(), rand_off(), rand_off());
      drain();

      // no active dimension
      set_walk(3'd0, '1, rand_strides(), rand_strides(), rand_strides());
      repeat (2) push_cmd(ACT_ADVANCE, rand_off(), rand_off(), rand_off());
      push_cmd(ACT_START, rand_off(), rand_off(), rand_off());
      push_cmd(ACT_ADVANCE, '0, '0, '0);
      drain();

      directed = cmds_made;
      while (cmds_made - directed < 1350) begin
         case ($urandom_range(0, 9))
            0: begin
               act   = '1;
               sizes = '1;
               sa    = '1;
               sb    = '1;
               sc    = '1;
            end
            1: begin
               act   = 3'd4;
               sizes = '0;
               sa    = '0;
               sb    = '0;
               sc    = '0;
            end
            default: begin
               act = ($urandom_range(0, 4) == 0) ? ACT_BITS'($urandom_range(0, 7))
                                                  : ACT_BITS'($urandom_range(1, 4));
               for (d = 0; d < MAX_DIMS; d++) begin
                  case ($urandom_range(0, 11))
                     0: sz = 0;
                     1: sz = $urandom_range(0, 4095);
                     default: sz = $urandom_range(1, 4);
                  endcase
                  sizes[DIM_BITS*d +: DIM_BITS] = DIM_BITS'(sz);
               end
               sa = rand_strides();
               sb = rand_strides();
               sc = rand_strides();
            end
         endcase
         set_walk(act, sizes, sa, sb, sc);

         lim  = (int'(act) > MAX_DIMS) ? MAX_DIMS : int'(act);
         span = 1;
         for (d = 0; d < lim; d++) begin
            sz = int'(sizes[DIM_BITS*d +: DIM_BITS]);
            if (sz == 0) sz = 1;
            span = span * sz;
            if (span > 48) span = 48;
         end

         // mostly whole walks; sometimes carry on from the previous setting
         mark = cmds_made;
         if ($urandom_range(0, 3) != 0) push_cmd(ACT_START, rand_off(), rand_off(), rand_off());
         while (cmds_made - mark < 40) begin
            steps = span + $urandom_range(0, 2);
            if ($urandom_range(0, 7) == 0) steps = $urandom_range(0, steps);
            repeat (steps) push_cmd(ACT_ADVANCE, rand_off(), rand_off(), rand_off());
            push_cmd(ACT_START, rand_off(), rand_off(), rand_off());
         end
         drain();
      end

      repeat (4) @(posedge clock);
      $display("walked %0d requests (%0d starts) under %0d register settings,",
               reqs_sent, starts_sent, settings_loaded);
      $display("%0d address sets checked, %0d mismatches", rsps_checked, fail_count);
      if (fail_count == 0) begin
         $display("** strided_tensor_address_walker_core: PASSED **");
      end else begin
         $display("** strided_tensor_address_walker_core: FAILED **");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("timeout: %0d requests still pending", walk_cmd_q.size() + due_addr_q.size());
      $display("** strided_tensor_address_walker_core: FAILED **");
      $finish;
   end

endmodule

[files.f]
+incdir+sv
sv/stwalk_pkg.sv
sv/stwalk_cell.sv
sv/strided_tensor_address_walker_core.sv
test/tb_strided_tensor_address_walker_core.sv
